// ===== rtl/npc_pkg.sv =====
package npc_pkg;

	localparam int unsigned IDX_W     = 8;
	localparam int unsigned COMP_W    = 8;
	localparam int unsigned COLOR_W   = 3 * COMP_W;
	localparam int unsigned SQ_W      = 2 * COMP_W;
	localparam int unsigned DIST_W    = 18;
	localparam int unsigned NUM_CELLS = 3;
	localparam int unsigned SCAN_W    = IDX_W + 1;
	localparam int unsigned MAX_DIST  = 195075;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [COMP_W-1:0]  comp_t;
	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [DIST_W-1:0]  dist_t;

	// one entry travelling down the distance chain
	typedef struct packed {
		logic   valid;
		idx_t   idx;
		color_t color;
		dist_t  sqdist;
	} beat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HOLD
	} state_t;

endpackage

// ===== rtl/npc_if.sv =====
interface npc_req_if;
	logic          valid;
	logic          ready;
	logic          action;
	npc_pkg::idx_t entry_index;
	npc_pkg::comp_t red;
	npc_pkg::comp_t green;
	npc_pkg::comp_t blue;

	modport source (output valid, action, entry_index, red, green, blue, input ready);
	modport sink (input valid, action, entry_index, red, green, blue, output ready);
endinterface

interface npc_rsp_if;
	logic           valid;
	logic           ready;
	npc_pkg::idx_t  best_index;
	npc_pkg::dist_t best_distance;
	logic           exact_match;

	modport source (output valid, best_index, best_distance, exact_match, input ready);
	modport sink (input valid, best_index, best_distance, exact_match, output ready);
endinterface

// ===== rtl/npc_ram.sv =====
module npc_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/npc_cell.sv =====
module npc_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  npc_pkg::comp_t query,
	input  logic           flush,
	input  npc_pkg::beat_t beat_in,
	output npc_pkg::beat_t beat_out
);

	npc_pkg::comp_t  query_q;
	npc_pkg::comp_t  entry;
	npc_pkg::comp_t  diff;
	logic [npc_pkg::SQ_W-1:0] sq;
	npc_pkg::beat_t  beat_q;

	// the cell works on the top byte and rotates the next channel into place
	assign entry = beat_in.color[npc_pkg::COLOR_W-1 -: npc_pkg::COMP_W];
	assign diff  = (entry >= query_q) ? (entry - query_q) : (query_q - entry);
	assign sq    = diff * diff;

	always_ff @(posedge clk) begin
		if (load) begin
			query_q <= query;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q <= '0;
		end else begin
			beat_q.valid  <= beat_in.valid && !flush;
			beat_q.idx    <= beat_in.idx;
			beat_q.color  <= {beat_in.color[npc_pkg::COLOR_W-npc_pkg::COMP_W-1:0], entry};
			beat_q.sqdist <= beat_in.sqdist + npc_pkg::DIST_W'(sq);
		end
	end

	assign beat_out = beat_q;

endmodule

// ===== rtl/nearest_palette_color_core.sv =====
// Palette write: the request port takes another beat in the next cycle.
// Query: the scan covers up to SCAN_COUNT palette entries, where SCAN_COUNT is
// min(PALETTE_ENTRIES, 256); one palette read per cycle feeds a chain of three
// distance cells, and a zero distance ends the scan early. One query at a time.
// A finished result waits in an output register while new beats are taken.
// arst_n clears control state; palette contents are undefined until written.
module nearest_palette_color_core #(
	parameter int unsigned PALETTE_ENTRIES = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	npc_req_if.sink   req,
	npc_rsp_if.source rsp
);

	localparam int unsigned AW         = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam int unsigned SCAN_COUNT = (PALETTE_ENTRIES < 256) ? PALETTE_ENTRIES : 256;
	localparam npc_pkg::idx_t LAST_IDX = npc_pkg::IDX_W'(SCAN_COUNT - 1);
	localparam logic [npc_pkg::SCAN_W-1:0] SCAN_END = npc_pkg::SCAN_W'(SCAN_COUNT);

	npc_pkg::state_t state_q, state_d;

	logic req_fire, query_go, write_go, write_ok;
	logic issue, finish, load_out, take;
	logic [npc_pkg::SCAN_W-1:0] issue_q;
	logic           v_s1;
	npc_pkg::idx_t  idx_s1;
	npc_pkg::color_t rdata;
	npc_pkg::beat_t beat [npc_pkg::NUM_CELLS+1];
	npc_pkg::comp_t qcomp [npc_pkg::NUM_CELLS];
	npc_pkg::beat_t tail;

	npc_pkg::idx_t  best_idx_q;
	npc_pkg::dist_t best_dist_q;
	logic           out_valid_q;
	npc_pkg::idx_t  out_idx_q;
	npc_pkg::dist_t out_dist_q;

	assign req_fire = req.valid && req.ready;
	assign query_go = req_fire && (req.action == npc_pkg::ACT_QUERY);
	assign write_ok = 32'(req.entry_index) < PALETTE_ENTRIES;
	assign write_go = req_fire && (req.action == npc_pkg::ACT_WRITE) && write_ok;

	npc_ram #(
		.WIDTH(npc_pkg::COLOR_W),
		.DEPTH(PALETTE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (write_go),
		.waddr(AW'(req.entry_index)),
		.wdata({req.red, req.green, req.blue}),
		.re   (issue),
		.raddr(AW'(issue_q[npc_pkg::IDX_W-1:0])),
		.rdata(rdata)
	);

	assign qcomp[0] = req.red;
	assign qcomp[1] = req.green;
	assign qcomp[2] = req.blue;

	assign beat[0] = '{valid: v_s1, idx: idx_s1, color: rdata, sqdist: '0};

	for (genvar k = 0; k < npc_pkg::NUM_CELLS; k++) begin : g_cell
		npc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.load    (query_go),
			.query   (qcomp[k]),
			.flush   (finish),
			.beat_in (beat[k]),
			.beat_out(beat[k+1])
		);
	end

	assign tail   = beat[npc_pkg::NUM_CELLS];
	assign finish = (state_q == npc_pkg::ST_SCAN) && tail.valid &&
		((tail.idx == LAST_IDX) || (tail.sqdist == '0));
	// first entry always wins; later ones only on a strict improvement
	assign take   = (state_q == npc_pkg::ST_SCAN) && tail.valid &&
		((tail.idx == '0) || (tail.sqdist < best_dist_q));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			npc_pkg::ST_IDLE: begin
				if (query_go) begin
					state_d = npc_pkg::ST_SCAN;
				end
			end
			npc_pkg::ST_SCAN: begin
				if (finish) begin
					state_d = npc_pkg::ST_HOLD;
				end
			end
			npc_pkg::ST_HOLD: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = npc_pkg::ST_IDLE;
				end
			end
			default: state_d = npc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		issue     = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			npc_pkg::ST_IDLE: req.ready = 1'b1;
			npc_pkg::ST_SCAN: issue = (issue_q != SCAN_END);
			npc_pkg::ST_HOLD: load_out = !out_valid_q || rsp.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= npc_pkg::ST_IDLE;
			issue_q     <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (query_go) begin
				issue_q <= '0;
			end else if (issue) begin
				issue_q <= issue_q + 1'b1;
			end
			v_s1 <= issue && !finish;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= issue_q[npc_pkg::IDX_W-1:0];
		if (take) begin
			best_idx_q  <= tail.idx;
			best_dist_q <= tail.sqdist;
		end
		if (load_out) begin
			out_idx_q  <= best_idx_q;
			out_dist_q <= best_dist_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.best_index    = out_idx_q;
	assign rsp.best_distance = out_dist_q;
	assign rsp.exact_match   = (out_dist_q == '0);

endmodule

// ===== rtl/npc_checker.sv =====
module npc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           req_action,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input npc_pkg::dist_t rsp_best_distance,
	input logic           rsp_exact_match
);

	// hold a result until it is taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat dropped before it was taken");

	// a query occupies the block, so the next beat waits
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_action == npc_pkg::ACT_QUERY) |=> !req_ready)
		else $error("request taken in the cycle after a query");

	a_exact_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_exact_match == (rsp_best_distance == '0)))
		else $error("exact flag disagrees with distance");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(rsp_best_distance) <= npc_pkg::MAX_DIST))
		else $error("distance above the largest RGB distance");

endmodule

bind nearest_palette_color_core npc_checker u_npc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_action       (req.action),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_best_distance(rsp.best_distance),
	.rsp_exact_match  (rsp.exact_match)
);
